/* hw/rtl/ssp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the serial setpoint command parser.
package ssp_pkg;

   localparam int unsigned MAX_PAYLOAD = 9;
   localparam int unsigned COUNT_W     = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned KEEP_BYTES  = 3;
   localparam int unsigned KEEP_IDX_W  = $clog2(KEEP_BYTES);

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned PERIOD_W = 10;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned CSR_AW   = 3;

   localparam logic [PERIOD_W-1:0] PERIOD_LIMIT_RESET = 10'd999;

   // csr register word index (paddr[2])
   localparam logic CSR_IDX_PERIOD_LIMIT = 1'b0;

   // parser phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_COMMAND = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_EXECUTE = 2'd3;

   // characters
   localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
   localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

endpackage

/* hw/rtl/ssp_channels.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the parser input and result items.
interface ssp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blower_speed;
   logic [9:0] move_period;
   logic       blower_changed;
   logic       blower_save;
   logic       period_save;
   logic       boot_request;

   modport source (output valid, output blower_speed, output move_period,
                   output blower_changed, output blower_save, output period_save,
                   output boot_request, input ready);
   modport sink   (input valid, input blower_speed, input move_period,
                   input blower_changed, input blower_save, input period_save,
                   input boot_request, output ready);
endinterface

/* hw/rtl/serial_setpoint_command_parser_top.sv */
`timescale 1ns / 1ps
// Serial setpoint command parser: frame decode, setpoint update and csr port.
//
// req_ch carries one received serial byte per item. Frames are 'S', 'B' or
// 'P', up to MAX_PAYLOAD payload bytes, 'E', then one more byte that runs
// the command. rsp_ch returns exactly one item per byte: the blower speed
// and move period after that byte, the blower/save strobes and the sticky
// boot request (0x30 followed by 0x20).
// A byte accepted into the input register passes through one step of parse
// logic, and its result is loaded into the result register.
// Throughput: one item per cycle while rsp_ch does not stall; the parse state
// lives in flip-flops and is updated in the same cycle the result register loads.
// When rsp_ch stalls, the result register holds and the input register
// still takes one more byte; req_ch.ready drops once both are full.
// Reset (synchronous, active high) returns to header phase, clears both
// setpoints and the boot flag, and sets period_limit to 999.
// csr: period_limit at address 0; writes complete in the APB access cycle.
module serial_setpoint_command_parser_top
   import ssp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ssp_req_if.sink           req_ch,
   ssp_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [PERIOD_W-1:0] limit_ff;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   logic [1:0]          phase_ff, phase_in;
   logic [BYTE_W-1:0]   prev_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                is_period_ff, is_period_in;
   logic [BYTE_W-1:0]   pay_ff [KEEP_BYTES];
   logic                pay_we;
   logic [BYTE_W-1:0]   blower_ff, blower_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                boot_ff, boot_in;

   logic                out_valid_ff;
   logic                changed_ff, changed_in;
   logic                bsave_ff, bsave_in;
   logic                psave_ff, psave_in;

   logic                out_free;
   logic                step;
   logic [BYTE_W-1:0]   b;
   logic [BYTE_W-1:0]   b0;
   logic [BYTE_W-1:0]   d0, d1;
   logic [BYTE_W-1:0]   two_digit;
   logic [15:0]         e0, e1, e2;
   logic [15:0]         three_digit;
   logic [PERIOD_W-1:0] three_clamped;
   logic                b0_is_digit;
   logic [BYTE_W-1:0]   b0_digit;

   // csr
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_PERIOD_LIMIT) ?
                       CSR_DW'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= PERIOD_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == CSR_IDX_PERIOD_LIMIT) begin
         limit_ff <= csr_pwdata[PERIOD_W-1:0];
      end
   end

   // handshake
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign step         = in_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   // value decode from the held payload bytes
   assign b  = in_byte_ff;
   assign b0 = pay_ff[0];
   assign d0 = pay_ff[0] - CH_0;
   assign d1 = pay_ff[1] - CH_0;
   assign two_digit = d0 * 8'd10 + d1;

   assign e0 = {8'h00, pay_ff[0]} - {8'h00, CH_0};
   assign e1 = {8'h00, pay_ff[1]} - {8'h00, CH_0};
   assign e2 = {8'h00, pay_ff[2]} - {8'h00, CH_0};
   assign three_digit   = e0 * 16'd100 + e1 * 16'd10 + e2;
   assign three_clamped = (three_digit > {6'b0, limit_ff}) ?
                          limit_ff : three_digit[PERIOD_W-1:0];

   assign b0_is_digit = b0 inside {[CH_0:CH_9]};
   assign b0_digit    = b0 - CH_0;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      is_period_in = is_period_ff;
      blower_in    = blower_ff;
      period_in    = period_ff;
      changed_in   = 1'b0;
      bsave_in     = 1'b0;
      psave_in     = 1'b0;
      pay_we       = 1'b0;
      boot_in      = boot_ff || (prev_ff == CH_0 && b == CH_SPACE);

      case (phase_ff)
         PH_HEADER: begin
            if (b == CH_S) begin
               phase_in = PH_COMMAND;
            end
         end
         PH_COMMAND: begin
            if (b == CH_B || b == CH_P) begin
               is_period_in = (b == CH_P);
               count_in     = '0;
               phase_in     = PH_PAYLOAD;
            end else begin
               phase_in = PH_HEADER;
            end
         end
         PH_PAYLOAD: begin
            if (b == CH_E) begin
               phase_in = PH_EXECUTE;
            end else if (count_ff >= COUNT_W'(MAX_PAYLOAD)) begin
               phase_in = PH_HEADER;
            end else begin
               pay_we   = (count_ff < COUNT_W'(KEEP_BYTES));
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            if (is_period_ff) begin
               if (count_ff == COUNT_W'(3)) begin
                  period_in = three_clamped;
                  psave_in  = 1'b1;
               end else if (count_ff == COUNT_W'(2)) begin
                  period_in = {2'b00, two_digit};
                  psave_in  = 1'b1;
               end else if (count_ff == COUNT_W'(1)) begin
                  psave_in = 1'b1;
                  if (b0 == CH_PLUS) begin
                     if (period_ff < limit_ff) begin
                        period_in = period_ff + 1'b1;
                     end
                  end else if (b0 == CH_MINUS) begin
                     if (period_ff != '0) begin
                        period_in = period_ff - 1'b1;
                     end
                  end else if (b0_is_digit) begin
                     period_in = {2'b00, b0_digit};
                  end
               end
            end else begin
               if (count_ff == COUNT_W'(2)) begin
                  blower_in  = two_digit;
                  changed_in = 1'b1;
                  bsave_in   = 1'b1;
               end else if (count_ff == COUNT_W'(1)) begin
                  changed_in = 1'b1;
                  bsave_in   = 1'b1;
                  if (b0 == CH_PLUS) begin
                     blower_in = blower_ff + 1'b1;
                  end else if (b0 == CH_MINUS) begin
                     if (blower_ff != '0) begin
                        blower_in = blower_ff - 1'b1;
                     end
                  end else if (b0_is_digit) begin
                     blower_in = b0_digit;
                  end
               end
            end
         end
      endcase
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         prev_ff      <= '0;
         count_ff     <= '0;
         is_period_ff <= 1'b0;
         blower_ff    <= '0;
         period_ff    <= '0;
         boot_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         prev_ff      <= b;
         count_ff     <= count_in;
         is_period_ff <= is_period_in;
         blower_ff    <= blower_in;
         period_ff    <= period_in;
         boot_ff      <= boot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && pay_we) begin
         pay_ff[count_ff[KEEP_IDX_W-1:0]] <= b;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         changed_ff <= changed_in;
         bsave_ff   <= bsave_in;
         psave_ff   <= psave_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.blower_speed   = blower_ff;
   assign rsp_ch.move_period    = period_ff;
   assign rsp_ch.blower_changed = changed_ff;
   assign rsp_ch.blower_save    = bsave_ff;
   assign rsp_ch.period_save    = psave_ff;
   assign rsp_ch.boot_request   = boot_ff;

   // checks
   a_save_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(bsave_ff && psave_ff))
      else $error("blower and period save in one item");

   a_changed_saves: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && changed_ff |-> bsave_ff)
      else $error("blower change without save strobe");

   a_boot_sticky: assert property (@(posedge clock) disable iff (reset)
      boot_ff |=> boot_ff)
      else $error("boot request cleared without reset");

   a_strobe_only_execute: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff != PH_EXECUTE |=> !bsave_ff && !psave_ff)
      else $error("save strobe outside execute phase");

endmodule
